FILE: rtl/ilpr_pkg.sv
package ilpr_pkg;

    // Table geometry
    localparam int TABLE_DEPTH    = 64;
    localparam int NUM_INTERFACES = 16;
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Field widths
    localparam int ADDR_W = 32;
    localparam int LEN_W  = 6;
    localparam int IF_W   = 4;
    localparam int TTL_W  = 8;
    localparam int ST_W   = 3;

    // Stream widths (whole bytes)
    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 48;

    // Longest prefix that a route can carry
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

    // Result status codes
    typedef enum logic [ST_W-1:0] {
        ST_ADDED       = 3'd0,
        ST_FORWARDED   = 3'd1,
        ST_TTL_EXPIRED = 3'd2,
        ST_NO_ROUTE    = 3'd3,
        ST_TABLE_FULL  = 3'd4
    } status_t;

    // Operation codes on the input tuser
    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_ROUTE = 1'b1
    } op_t;

    // What the controller asks the datapath to report
    typedef enum logic [1:0] {
        RES_ADDED,
        RES_FULL,
        RES_EXPIRED,
        RES_LOOKUP
    } res_kind_t;

    // One stored route
    typedef struct packed {
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  length;
        logic              has_hop;
        logic [ADDR_W-1:0] hop_addr;
        logic [IF_W-1:0]   iface;
    } entry_t;

    // Controller to datapath
    typedef struct packed {
        logic             load_in;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             cmp_en;
        logic             clear_best;
        logic             out_load;
        res_kind_t        res_kind;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        op_t  op;
        logic ttl_low;
    } stat_t;

    // Network mask of a prefix length (0 to 32)
    function automatic logic [ADDR_W-1:0] mask_of(input logic [LEN_W-1:0] len);
        mask_of = ~({ADDR_W{1'b1}} >> len);
    endfunction

endpackage

FILE: rtl/ilpr_ctrl.sv
module ilpr_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    input  ilpr_pkg::stat_t stat,
    output ilpr_pkg::cmd_t  cmd
);

    typedef enum logic [1:0] {
        IDLE,
        CHECK,
        SCAN,
        DONE
    } state_t;

    state_t                       state_reg, state_next;
    logic [ilpr_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [ilpr_pkg::CNT_W-1:0]   idx_reg, idx_next;
    ilpr_pkg::res_kind_t          kind_reg, kind_next;
    logic                         m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == IDLE);
    assign m_valid = m_valid_reg;

    // Sequence the add, the table scan and the result hand-off
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        kind_next    = kind_reg;
        m_valid_next = m_valid_reg;

        cmd            = '0;
        cmd.wr_addr    = count_reg[ilpr_pkg::IDX_W-1:0];
        cmd.rd_addr    = idx_reg[ilpr_pkg::IDX_W-1:0];
        cmd.res_kind   = kind_reg;

        // Retire the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = CHECK;
                end
            end
            CHECK: begin
                if (stat.op == ilpr_pkg::OP_ADD) begin
                    if (count_reg == ilpr_pkg::CNT_W'(ilpr_pkg::TABLE_DEPTH)) begin
                        kind_next = ilpr_pkg::RES_FULL;
                    end else begin
                        cmd.wr_en  = 1'b1;
                        count_next = count_reg + ilpr_pkg::CNT_W'(1);
                        kind_next  = ilpr_pkg::RES_ADDED;
                    end
                    state_next = DONE;
                end else if (stat.ttl_low) begin
                    kind_next  = ilpr_pkg::RES_EXPIRED;
                    state_next = DONE;
                end else begin
                    cmd.clear_best = 1'b1;
                    kind_next      = ilpr_pkg::RES_LOOKUP;
                    idx_next       = '0;
                    state_next     = (count_reg == '0) ? DONE : SCAN;
                    if (count_reg != '0) begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_addr = '0;
                        idx_next    = ilpr_pkg::CNT_W'(1);
                    end
                end
            end
            SCAN: begin
                // Compare the entry read last cycle, issue the next read
                cmd.cmp_en = 1'b1;
                if (idx_reg != count_reg) begin
                    cmd.rd_en = 1'b1;
                    idx_next  = idx_reg + ilpr_pkg::CNT_W'(1);
                end else begin
                    state_next = DONE;
                end
            end
            DONE: begin
                // Load the result once the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            kind_reg    <= ilpr_pkg::RES_ADDED;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            kind_reg    <= kind_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef SYNTHESIS
    // Table never holds more routes than it has rows
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= ilpr_pkg::CNT_W'(ilpr_pkg::TABLE_DEPTH))
        else $error("route count beyond table depth");

    // A result never overwrites one that is still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result loaded over a pending result");

    // Scan reads only rows that were written
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.rd_en && state_reg == SCAN) |-> (idx_reg < count_reg))
        else $error("scan read beyond stored routes");

    // Route count moves only on a table write
    assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && count_reg != $past(count_reg)) |-> $past(cmd.wr_en))
        else $error("route count changed without a write");
`endif

endmodule

FILE: rtl/ilpr_dpath.sv
module ilpr_dpath (
    input  logic                             aclk,
    input  logic [ilpr_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             s_tuser,
    output logic [ilpr_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [ilpr_pkg::ST_W-1:0]        m_tuser,
    input  ilpr_pkg::cmd_t                   cmd,
    output ilpr_pkg::stat_t                  stat
);

    // Captured input item
    ilpr_pkg::op_t                   op_reg;
    ilpr_pkg::entry_t                new_reg;
    logic [ilpr_pkg::ADDR_W-1:0]     dest_reg;
    logic [ilpr_pkg::TTL_W-1:0]      ttl_reg;

    // Route memory and its registered read port
    ilpr_pkg::entry_t                mem [ilpr_pkg::TABLE_DEPTH];
    ilpr_pkg::entry_t                rd_reg;

    // Best match so far
    logic                            found_reg;
    logic [ilpr_pkg::LEN_W-1:0]      best_len_reg;
    logic                            best_has_hop_reg;
    logic [ilpr_pkg::ADDR_W-1:0]     best_hop_reg;
    logic [ilpr_pkg::IF_W-1:0]       best_if_reg;

    // Output register
    logic [ilpr_pkg::M_TDATA_W-1:0]  m_tdata_reg;
    logic [ilpr_pkg::ST_W-1:0]       m_tuser_reg;

    logic [ilpr_pkg::LEN_W-1:0]      in_len;
    logic                            hit;
    logic                            better;
    logic                            if_ok;
    ilpr_pkg::status_t               res_status;
    logic [ilpr_pkg::IF_W-1:0]       res_if;
    logic [ilpr_pkg::ADDR_W-1:0]     res_addr;
    logic [ilpr_pkg::TTL_W-1:0]      res_ttl;

    // Saturate prefix length at 32
    assign in_len = (s_tdata[37:32] > ilpr_pkg::MAX_LEN) ? ilpr_pkg::MAX_LEN : s_tdata[37:32];

    assign stat.op      = op_reg;
    assign stat.ttl_low = (ttl_reg[ilpr_pkg::TTL_W-1:1] == '0);

    // Capture the item
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg           <= ilpr_pkg::op_t'(s_tuser);
            new_reg.prefix   <= s_tdata[31:0];
            new_reg.length   <= in_len;
            new_reg.has_hop  <= s_tdata[38];
            new_reg.hop_addr <= s_tdata[70:39];
            new_reg.iface    <= s_tdata[74:71];
            dest_reg         <= s_tdata[106:75];
            ttl_reg          <= s_tdata[114:107];
        end
    end

    // Append a route
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[cmd.wr_addr] <= new_reg;
        end
    end

    // Read one route per cycle
    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_reg <= mem[cmd.rd_addr];
        end
    end

    // Match under mask; strictly longer wins so the earliest keeps ties
    assign hit    = (((dest_reg ^ rd_reg.prefix) & ilpr_pkg::mask_of(rd_reg.length)) == '0);
    assign better = hit && (!found_reg || (rd_reg.length > best_len_reg));

    always_ff @(posedge aclk) begin
        if (cmd.clear_best) begin
            found_reg    <= 1'b0;
            best_len_reg <= '0;
        end else if (cmd.cmp_en && better) begin
            found_reg        <= 1'b1;
            best_len_reg     <= rd_reg.length;
            best_has_hop_reg <= rd_reg.has_hop;
            best_hop_reg     <= rd_reg.hop_addr;
            best_if_reg      <= rd_reg.iface;
        end
    end

    // Form the result
    assign if_ok = (int'(best_if_reg) < ilpr_pkg::NUM_INTERFACES);

    always_comb begin
        res_status = ilpr_pkg::ST_ADDED;
        res_if     = '0;
        res_addr   = '0;
        res_ttl    = '0;
        case (cmd.res_kind)
            ilpr_pkg::RES_ADDED:   res_status = ilpr_pkg::ST_ADDED;
            ilpr_pkg::RES_FULL:    res_status = ilpr_pkg::ST_TABLE_FULL;
            ilpr_pkg::RES_EXPIRED: res_status = ilpr_pkg::ST_TTL_EXPIRED;
            ilpr_pkg::RES_LOOKUP: begin
                if (found_reg && if_ok) begin
                    res_status = ilpr_pkg::ST_FORWARDED;
                    res_if     = best_if_reg;
                    res_addr   = best_has_hop_reg ? best_hop_reg : dest_reg;
                    res_ttl    = ttl_reg - ilpr_pkg::TTL_W'(1);
                end else begin
                    res_status = ilpr_pkg::ST_NO_ROUTE;
                end
            end
            default: res_status = ilpr_pkg::ST_NO_ROUTE;
        endcase
    end

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= {4'b0000, res_ttl, res_addr, res_if};
            m_tuser_reg <= res_status;
        end
    end

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

endmodule

FILE: rtl/ipv4_longest_prefix_router_top.sv
// Channel   Direction  tdata (low bit up)                                  tuser
// s_axis    in         net_prefix, mask_len, has_next_hop,                 operation
//                      next_hop_addr, route_interface, dest_addr, ttl_in
// m_axis    out        out_interface, forward_addr, ttl_out                status
//
// One item at a time. An add or a dropped datagram is captured on accept, checked,
// then its result waits in DONE for the output register; a lookup first scans every
// stored route through the single read port of the route memory, one route per cycle.
// Reset is synchronous, active low, and empties the table; no clearing pass.
// A held result does not block accepting the next item; only its own result
// waits for the output register to free up.
module ipv4_longest_prefix_router_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // net_prefix, mask_len, has_next_hop, next_hop_addr,
    // route_interface, dest_addr, ttl_in, zero fill
    input  logic [ilpr_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // operation
    input  logic [0:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_interface, forward_addr, ttl_out, zero fill
    output logic [ilpr_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // status
    output logic [ilpr_pkg::ST_W-1:0]       m_axis_tuser
);

    ilpr_pkg::cmd_t  cmd;
    ilpr_pkg::stat_t stat;

    ilpr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ilpr_dpath u_dpath (
        .aclk    (aclk),
        .s_tdata (s_axis_tdata),
        .s_tuser (s_axis_tuser[0]),
        .m_tdata (m_axis_tdata),
        .m_tuser (m_axis_tuser),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule
